// ----- hdl/msgcd_pkg.sv -----
`default_nettype none

package msgcd_pkg;

	// Field width and histogram depth follow from the 16-bit value field
	localparam int unsigned ValueW    = 16;
	localparam int unsigned HistDepth = 2 ** ValueW;
	localparam int unsigned HistW     = 2;

	// Largest value that is counted; the search cannot start above the field range
	localparam int unsigned MAX_VALUE = 65535;
	localparam int unsigned SearchTop = (MAX_VALUE > HistDepth - 1) ? HistDepth - 1 : MAX_VALUE;

	// Saturation point of a histogram entry and hit threshold of the running sum
	localparam int unsigned PairCount = 2;

	// Queue between front and back
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QPtrW      = $clog2(QueueDepth);

	// One item as it waits in the queue, already classified
	typedef struct packed {
		logic [ValueW-1:0] value;
		logic              last;
		logic              countable;
	} msgcd_item_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_LOAD,
		ST_SEARCH,
		ST_RESULT
	} msgcd_state_t;

endpackage

`default_nettype wire

// ----- hdl/max_pairwise_gcd_sieve.sv -----
// Greatest GCD over all pairs of a set of values, by a sieve over multiples.
// Input channel (item_valid/item_ready, value, last): one set member per item;
// last marks the final member. A four-entry queue sits behind the input, and
// the back end drains it into a histogram memory at one item per cycle while
// it is in its load state, so a set loads at one item per cycle.
// Output channel (result_valid/result_ready, best_divisor, found): one result
// per set. found is 0 and best_divisor 0 when fewer than two values counted;
// zero values and values above MAX_VALUE are not counted.
// After the last item the back end walks divisors d from the top down, one
// histogram read per cycle over the multiples of d; the walk ends at the
// first d covering two values, or after d = 1 when no d covers two.
// The result sits in an output register; a held result_ready stalls only the
// hand-over, after which a pass over every histogram entry clears it while the
// queue keeps taking items. Reset starts with the same clearing pass; items
// are taken into the queue meanwhile but not processed.

`default_nettype none

module max_pairwise_gcd_sieve import msgcd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire logic [ValueW-1:0] value,
	input  wire logic              last,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output logic [ValueW-1:0]      best_divisor,
	output logic                   found
);

	msgcd_item_t head;
	logic        head_valid;
	logic        pop;

	msgcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.value      (value),
		.last       (last),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	msgcd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.best_divisor (best_divisor),
		.found        (found)
	);

endmodule

`default_nettype wire

// ----- hdl/msgcd_front.sv -----
`default_nettype none

module msgcd_front import msgcd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire logic [ValueW-1:0] value,
	input  wire logic              last,
	output msgcd_item_t            head,
	output logic                   head_valid,
	input  wire logic              pop
);

	msgcd_item_t      q_mem [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QPtrW:0]   cnt_q;
	logic             push;
	msgcd_item_t      cls;

	// Classify: zero and out-of-range values are passed on but not counted
	always_comb begin
		cls.value     = value;
		cls.last      = last;
		cls.countable = (value != '0) && (32'(value) <= 32'(MAX_VALUE));
	end

	assign item_ready = cnt_q != (QPtrW + 1)'(QueueDepth);
	assign push       = item_valid && item_ready;
	assign head       = q_mem[rd_ptr_q];
	assign head_valid = cnt_q != '0;

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/msgcd_back.sv -----
`default_nettype none

module msgcd_back import msgcd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire msgcd_item_t       head,
	input  wire logic              head_valid,
	output logic                   pop,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output logic [ValueW-1:0]      best_divisor,
	output logic                   found
);

	logic [HistW-1:0]  hist_mem [HistDepth];

	msgcd_state_t      state_q, state_d;
	logic [ValueW-1:0] clr_q;

	// load pipeline: item whose histogram entry has been read
	msgcd_item_t       item_s1;
	logic              vld_s1;
	logic              wr_vld_q;
	logic [ValueW-1:0] wr_addr_q;
	logic [HistW-1:0]  wr_data_q;

	// search registers
	logic [ValueW-1:0] div_q;
	logic [ValueW:0]   mult_q;
	logic [HistW-1:0]  cnt_q;
	logic              rd_vld_q;
	logic              hit_q;

	logic [HistW-1:0]  rdata_q;
	logic              out_vld_q;
	logic [ValueW-1:0] best_q;
	logic              found_q;

	logic              we;
	logic [ValueW-1:0] waddr;
	logic [HistW-1:0]  wdata;
	logic [ValueW-1:0] raddr;

	logic [HistW-1:0]  fwd;
	logic [HistW-1:0]  inc;
	logic              issue;
	logic [HistW:0]    cnt_sum;
	logic              hit_now;
	logic              span_end;
	logic              slot_free;

	// Load path: forward the previous write when it hit the same entry
	assign fwd = (wr_vld_q && (wr_addr_q == item_s1.value)) ? wr_data_q : rdata_q;
	assign inc = (fwd >= HistW'(PairCount)) ? HistW'(PairCount) : fwd + 1'b1;

	// Search path: one multiple read per cycle, its data summed in the cycle after the read
	assign issue    = mult_q <= (ValueW + 1)'(SearchTop);
	assign cnt_sum  = {1'b0, cnt_q} + (rd_vld_q ? {1'b0, rdata_q} : '0);
	assign hit_now  = cnt_sum >= (HistW + 1)'(PairCount);
	assign span_end = !issue && !rd_vld_q;

	assign slot_free = !out_vld_q || result_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (vld_s1 && item_s1.last) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				// a pair found, or the last divisor walked without one
				if (hit_now || (span_end && (div_q == ValueW'(1)))) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (slot_free) state_d = ST_CLEAR;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Memory port control and queue pop
	always_comb begin
		pop   = 1'b0;
		we    = 1'b0;
		waddr = item_s1.value;
		wdata = inc;
		raddr = mult_q[ValueW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_LOAD: begin
				pop   = head_valid && !(vld_s1 && item_s1.last);
				raddr = head.value;
				we    = vld_s1 && item_s1.countable;
			end
			ST_SEARCH: begin
				we = 1'b0;
			end
			ST_RESULT: begin
				we = 1'b0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Histogram memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			hist_mem[waddr] <= wdata;
		end
		rdata_q <= hist_mem[raddr];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head;
		end
		wr_addr_q <= waddr;
		wr_data_q <= wdata;
	end

	// Control, search and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			vld_s1    <= 1'b0;
			wr_vld_q  <= 1'b0;
			div_q     <= '0;
			mult_q    <= '0;
			cnt_q     <= '0;
			rd_vld_q  <= 1'b0;
			hit_q     <= 1'b0;
			out_vld_q <= 1'b0;
			best_q    <= '0;
			found_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			clr_q    <= (state_q == ST_CLEAR) ? clr_q + 1'b1 : '0;
			vld_s1   <= pop;
			wr_vld_q <= we && (state_q == ST_LOAD);

			// divisor walk
			if (state_q == ST_LOAD) begin
				div_q    <= ValueW'(SearchTop);
				mult_q   <= (ValueW + 1)'(SearchTop);
				cnt_q    <= '0;
				rd_vld_q <= 1'b0;
				hit_q    <= 1'b0;
			end else if (state_q == ST_SEARCH) begin
				rd_vld_q <= issue;
				priority if (hit_now) begin
					hit_q    <= 1'b1;
					rd_vld_q <= 1'b0;
				end else if (span_end) begin
					if (div_q != ValueW'(1)) begin
						div_q  <= div_q - 1'b1;
						mult_q <= {1'b0, div_q - 1'b1};
					end
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_sum[HistW-1:0];
					if (issue) begin
						mult_q <= mult_q + {1'b0, div_q};
					end
				end
			end

			// result register
			if ((state_q == ST_RESULT) && slot_free) begin
				out_vld_q <= 1'b1;
				best_q    <= hit_q ? div_q : '0;
				found_q   <= hit_q;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_vld_q;
	assign best_divisor = best_q;
	assign found        = found_q;

	// Checks
	a_pop_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_LOAD) && head_valid)
		else $error("queue popped outside load");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !found) |-> (best_divisor == '0))
		else $error("divisor reported without a pair");

	a_count_below_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (cnt_q < HistW'(PairCount)))
		else $error("running count held at saturation");

	a_mult_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (mult_q <= {1'b0, div_q} + (ValueW + 1)'(SearchTop)))
		else $error("multiple overran the search range");

	a_search_start: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LOAD) && (state_d == ST_SEARCH))
			|=> (div_q == ValueW'(SearchTop)) && (cnt_q == '0))
		else $error("search did not start at the top");

endmodule

`default_nettype wire
